// ===== hdl/multi_channel_byte_pipe_macros.svh =====
// Assertion macros for the byte pipe controller.
`ifndef MULTI_CHANNEL_BYTE_PIPE_MACROS_SVH
`define MULTI_CHANNEL_BYTE_PIPE_MACROS_SVH
`ifndef SYNTHESIS
`define MCBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MCBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/mcbp_pkg.sv =====
package mcbp_pkg;

  localparam int PIPE_W  = 3;
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 7;
  localparam int COUNT_W = 8;
  localparam int FILL_W  = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [FILL_W-1:0]  FILL_MAX  = 12'hFFF;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_OPEN    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY_BLOCK = 3'd1,
    ST_EOF         = 3'd2,
    ST_FULL_BLOCK  = 3'd3,
    ST_COUNT_ERR   = 3'd4
  } status_e;

  // One incoming request word
  typedef struct packed {
    req_e              kind;
    logic [PIPE_W-1:0] pipe;
    logic              rd_mode;
    logic              wr_mode;
    logic [DATA_W-1:0] wdata;
    logic [CNT_W-1:0]  cnt;
  } req_t;

  // One outgoing result word
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic              last;
    logic [FILL_W-1:0] fill;
  } res_t;

  // Memory port enables
  typedef struct packed {
    logic we;
    logic re;
  } mem_en_t;

endpackage

// ===== hdl/mcbp_state_mem.sv =====
module mcbp_state_mem import mcbp_pkg::*; #(
  parameter int ENTRIES = 8,
  parameter int WIDTH   = 40
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mem_en_t                               en_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0]   mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [WIDTH-1:0]   rdata_q;
  logic               rvalid_q;

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (en_i.we) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (en_i.re) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // Store and registered read
  always_ff @(posedge clk_i) begin
    if (en_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (en_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Unwritten entries read as zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== hdl/mcbp_byte_mem.sv =====
module mcbp_byte_mem import mcbp_pkg::*; #(
  parameter int ENTRIES = 32768
) (
  input  logic                                  clk_i,
  input  mem_en_t                               en_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                     wdata_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                     rdata_o
);

  logic [DATA_W-1:0] mem_q [ENTRIES];
  logic [DATA_W-1:0] rdata_q;

  // Write one byte, read one byte, read data registered
  always_ff @(posedge clk_i) begin
    if (en_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (en_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mcbp_ctrl.sv =====
`include "multi_channel_byte_pipe_macros.svh"

module mcbp_ctrl import mcbp_pkg::*; #(
  parameter int PIPE_DEPTH   = 4096,
  parameter int PIPE_COUNT   = 8,
  parameter int MAX_READ_RUN = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  req_t    in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output res_t    out_res_o,
  output mem_en_t st_en_o,
  output logic [(PIPE_COUNT > 1 ? $clog2(PIPE_COUNT) : 1)-1:0] st_waddr_o,
  output logic [(PIPE_COUNT > 1 ? $clog2(PIPE_COUNT) : 1)-1:0] st_raddr_o,
  output logic [2*$clog2(PIPE_DEPTH)+2*COUNT_W-1:0]            st_wdata_o,
  input  logic [2*$clog2(PIPE_DEPTH)+2*COUNT_W-1:0]            st_rdata_i,
  output mem_en_t bm_en_o,
  output logic [$clog2(PIPE_COUNT*PIPE_DEPTH)-1:0]             bm_waddr_o,
  output logic [$clog2(PIPE_COUNT*PIPE_DEPTH)-1:0]             bm_raddr_o,
  output logic [DATA_W-1:0]                                    bm_wdata_o,
  input  logic [DATA_W-1:0]                                    bm_rdata_i
);

  localparam int IW = $clog2(PIPE_DEPTH);
  localparam int PW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int AW = $clog2(PIPE_COUNT * PIPE_DEPTH);
  localparam int SW = 2 * IW + 2 * COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT,
    S_RUN
  } state_e;

  // Step a ring index with wrap
  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    logic [IW:0] s;
    s = (IW+1)'(i) + (IW+1)'(1);
    next_idx = (32'(s) >= PIPE_DEPTH) ? '0 : s[IW-1:0];
  endfunction

  // Clamp a byte count to the fill field
  function automatic logic [FILL_W-1:0] sat_fill(input logic [IW-1:0] h);
    sat_fill = (32'(h) > 32'(FILL_MAX)) ? FILL_MAX : FILL_W'(h);
  endfunction

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic              oor_q, oor_d;
  logic [AW-1:0]     base_q, base_d;
  logic [SW-1:0]     st_q, st_d;
  logic [IW-1:0]     ri_q, ri_d;
  logic [IW-1:0]     held_q, held_d;
  logic [CNT_W-1:0]  iss_left_q, iss_left_d;
  logic [CNT_W-1:0]  ld_left_q, ld_left_d;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;
  res_t              res_q, res_d;

  logic              accept, can_load, load, issue, in_oor;

  logic [IW-1:0]      r_cur, w_cur, w_new, have;
  logic [COUNT_W-1:0] rc_cur, wc_cur, rc_new, wc_new;
  logic [CNT_W-1:0]   cnt_clamp, run_len;
  logic               full, cnt_err, is_run, bm_we_look;
  res_t               res_look;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign can_load = !out_valid_q || out_ready_i;
  assign load     = (state_q == S_RUN) && rd_pend_q && can_load;
  assign issue    = (state_q == S_RUN) && (iss_left_q != '0) && (!rd_pend_q || can_load);
  assign in_oor   = 32'(in_req_i.pipe) >= PIPE_COUNT;

  // Unpack the pipe state word
  assign r_cur  = st_rdata_i[IW-1:0];
  assign w_cur  = st_rdata_i[2*IW-1:IW];
  assign rc_cur = st_rdata_i[2*IW +: COUNT_W];
  assign wc_cur = st_rdata_i[2*IW+COUNT_W +: COUNT_W];

  // Bytes held, one slot always left open
  assign have = (r_cur <= w_cur) ? (w_cur - r_cur)
              : IW'((IW+1)'(PIPE_DEPTH) - (IW+1)'(r_cur) + (IW+1)'(w_cur));
  assign full = 32'(have) >= (PIPE_DEPTH - 1);

  assign cnt_clamp = (32'(req_q.cnt) > MAX_READ_RUN) ? CNT_W'(MAX_READ_RUN) : req_q.cnt;
  assign run_len   = (32'(have) < 32'(cnt_clamp)) ? CNT_W'(have) : cnt_clamp;

  // Decide the request against the pipe state
  always_comb begin
    w_new           = w_cur;
    rc_new          = rc_cur;
    wc_new          = wc_cur;
    cnt_err         = 1'b0;
    is_run          = 1'b0;
    bm_we_look      = 1'b0;
    res_look.status = ST_OK;
    res_look.data   = '0;
    res_look.last   = 1'b1;
    res_look.fill   = sat_fill(have);
    case (req_q.kind)
      REQ_OPEN: begin
        cnt_err = (req_q.rd_mode && (rc_cur >= COUNT_MAX)) ||
                  (req_q.wr_mode && (wc_cur >= COUNT_MAX));
        if (!cnt_err) begin
          rc_new = rc_cur + COUNT_W'(req_q.rd_mode);
          wc_new = wc_cur + COUNT_W'(req_q.wr_mode);
        end
        res_look.status = cnt_err ? ST_COUNT_ERR : ST_OK;
      end
      REQ_RELEASE: begin
        cnt_err = (req_q.rd_mode && (rc_cur == '0)) ||
                  (req_q.wr_mode && (wc_cur == '0));
        if (!cnt_err) begin
          rc_new = rc_cur - COUNT_W'(req_q.rd_mode);
          wc_new = wc_cur - COUNT_W'(req_q.wr_mode);
        end
        res_look.status = cnt_err ? ST_COUNT_ERR : ST_OK;
      end
      REQ_WRITE: begin
        if (full) begin
          res_look.status = ST_FULL_BLOCK;
        end else begin
          bm_we_look    = 1'b1;
          w_new         = next_idx(w_cur);
          res_look.fill = sat_fill(have + IW'(1));
        end
      end
      REQ_READ: begin
        if (have == '0) begin
          res_look.status = (wc_cur != '0) ? ST_EMPTY_BLOCK : ST_EOF;
          res_look.fill   = '0;
        end else if (cnt_clamp != '0) begin
          is_run = 1'b1;
        end
      end
      default: begin
        res_look.status = ST_COUNT_ERR;
      end
    endcase
    // Pipe index past the last pipe
    if (oor_q) begin
      is_run          = 1'b0;
      bm_we_look      = 1'b0;
      res_look.status = ST_COUNT_ERR;
      res_look.fill   = '0;
    end
  end

  // Sequencer next state and memory ports
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    oor_d       = oor_q;
    base_d      = base_q;
    st_d        = st_q;
    ri_d        = ri_q;
    held_d      = held_q;
    iss_left_d  = iss_left_q;
    ld_left_d   = ld_left_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    res_d       = res_q;
    st_en_o     = '0;
    st_raddr_o  = PW'(in_req_i.pipe);
    st_waddr_o  = PW'(req_q.pipe);
    st_wdata_o  = {wc_new, rc_new, w_new, r_cur};
    bm_en_o     = '0;
    bm_waddr_o  = base_q + AW'(w_cur);
    bm_raddr_o  = base_q + AW'(ri_q);
    bm_wdata_o  = req_q.wdata;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d      = in_req_i;
          oor_d      = in_oor;
          base_d     = AW'(32'(in_req_i.pipe) * PIPE_DEPTH);
          st_en_o.re = !in_oor;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        st_d       = {wc_new, rc_new, w_new, r_cur};
        st_en_o.we = !oor_q && !is_run;
        bm_en_o.we = bm_we_look;
        if (is_run) begin
          ri_d       = r_cur;
          held_d     = have;
          iss_left_d = run_len;
          ld_left_d  = run_len;
          state_d    = S_RUN;
        end else if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = res_look;
          state_d     = S_IDLE;
        end else begin
          res_d   = res_look;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      S_RUN: begin
        if (issue) begin
          bm_en_o.re = 1'b1;
          ri_d       = next_idx(ri_q);
          iss_left_d = iss_left_q - CNT_W'(1);
        end
        if (load) begin
          out_valid_d  = 1'b1;
          out_d.status = ST_OK;
          out_d.data   = bm_rdata_i;
          out_d.last   = (ld_left_q == CNT_W'(1));
          out_d.fill   = sat_fill(held_q - IW'(1));
          held_d       = held_q - IW'(1);
          ld_left_d    = ld_left_q - CNT_W'(1);
          if (ld_left_q == CNT_W'(1)) begin
            // Write back the advanced read index
            st_en_o.we = 1'b1;
            st_wdata_o = {st_q[SW-1:IW], ri_q};
            state_d    = S_IDLE;
          end
        end
        rd_pend_d = issue ? 1'b1 : (load ? 1'b0 : rd_pend_q);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_left_q  <= '0;
      ld_left_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_left_q  <= iss_left_d;
      ld_left_q   <= ld_left_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    oor_q  <= oor_d;
    base_q <= base_d;
    st_q   <= st_d;
    ri_q   <= ri_d;
    held_q <= held_d;
    out_q  <= out_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `MCBP_ASSERT(a_ready_no_run, clk_i, rst_ni, in_ready_o |-> (iss_left_q == '0 && !rd_pend_q), "input ready with a read run still open")
  `MCBP_ASSERT(a_pend_in_run, clk_i, rst_ni, rd_pend_q |-> (state_q == S_RUN), "byte read pending outside a run")
  `MCBP_ASSERT(a_issue_ahead, clk_i, rst_ni, iss_left_q <= ld_left_q, "more reads left than bytes to deliver")
  `MCBP_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, load && ld_left_q == CNT_W'(1), state_q == S_IDLE && out_valid_q && out_q.last, "last byte of a run not delivered as last")

endmodule

// ===== hdl/multi_channel_byte_pipe.sv =====
// Multi-channel byte pipe: several byte ring buffers behind one request stream.
// Slave stream: one request word per handshake; tuser carries the request kind
// (open, release, write one byte, read), tdata the pipe, mode bits, byte and
// the read count. Master stream: result words; tuser carries the status, tdata
// the byte read and the fill level, tlast marks the final word of a request.
// Per-pipe indices and counts sit in a small state memory, the bytes in one
// shared byte memory; both have a registered read port.
// An accepted request is decided against its pipe state in S_LOOK; an open,
// release, write or single-word read result is then registered, through S_EMIT
// if the receiver stalls. A read run issues byte memory reads in S_RUN and
// delivers one byte per cycle while the receiver keeps taking them, paced by
// the single read port of the byte memory.
// A request is accepted only while the sequencer is idle; a finished word may
// still wait in the output register while the next request is taken.
// When the receiver stalls, the output register holds and the run pauses.
// After reset every pipe is empty with zero readers and writers; no clearing
// pass runs, so requests are taken from the first cycle.
module multi_channel_byte_pipe import mcbp_pkg::*; #(
  parameter int PIPE_DEPTH   = 4096,
  parameter int PIPE_COUNT   = 8,
  parameter int MAX_READ_RUN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pipe_index[2:0], open_for_read[3], open_for_write[4], write_data[12:5],
  // read_count[19:13], zero pad[23:20]
  input  logic [23:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], fill_level[19:8], zero pad[23:20]
  output logic [23:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int IW = $clog2(PIPE_DEPTH);
  localparam int PW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int AW = $clog2(PIPE_COUNT * PIPE_DEPTH);
  localparam int SW = 2 * IW + 2 * COUNT_W;

  req_t              in_req;
  res_t              out_res;
  mem_en_t           st_en, bm_en;
  logic [PW-1:0]     st_waddr, st_raddr;
  logic [SW-1:0]     st_wdata, st_rdata;
  logic [AW-1:0]     bm_waddr, bm_raddr;
  logic [DATA_W-1:0] bm_wdata, bm_rdata;

  // Unpack the request word
  assign in_req.kind    = req_e'(s_axis_tuser_i);
  assign in_req.pipe    = s_axis_tdata_i[2:0];
  assign in_req.rd_mode = s_axis_tdata_i[3];
  assign in_req.wr_mode = s_axis_tdata_i[4];
  assign in_req.wdata   = s_axis_tdata_i[12:5];
  assign in_req.cnt     = s_axis_tdata_i[19:13];

  mcbp_ctrl #(
    .PIPE_DEPTH   (PIPE_DEPTH),
    .PIPE_COUNT   (PIPE_COUNT),
    .MAX_READ_RUN (MAX_READ_RUN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (in_req),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res),
    .st_en_o     (st_en),
    .st_waddr_o  (st_waddr),
    .st_raddr_o  (st_raddr),
    .st_wdata_o  (st_wdata),
    .st_rdata_i  (st_rdata),
    .bm_en_o     (bm_en),
    .bm_waddr_o  (bm_waddr),
    .bm_raddr_o  (bm_raddr),
    .bm_wdata_o  (bm_wdata),
    .bm_rdata_i  (bm_rdata)
  );

  mcbp_state_mem #(
    .ENTRIES (PIPE_COUNT),
    .WIDTH   (SW)
  ) u_state_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (st_en),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  mcbp_byte_mem #(
    .ENTRIES (PIPE_COUNT * PIPE_DEPTH)
  ) u_byte_mem (
    .clk_i   (clk_i),
    .en_i    (bm_en),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // Pack the result word
  assign m_axis_tdata_o = {4'b0000, out_res.fill, out_res.data};
  assign m_axis_tuser_o = out_res.status;
  assign m_axis_tlast_o = out_res.last;

endmodule
